@@ rtl/core/avlc_fhp_pkg.sv @@
// ----------------------------------------------------------------------------
// AVLC frame header parser package
// Shared types, protocol constants and the bytewise CRC-16/CCITT update.
// ----------------------------------------------------------------------------
package avlc_fhp_pkg;

    localparam int MAX_FRAME_LEN_DEF = 2048;
    localparam int COUNT_W           = 12;
    localparam int COUNT_MAX         = 4095;

    localparam logic [15:0] FCS_INIT    = 16'hFFFF;
    localparam logic [15:0] FCS_RESIDUE = 16'hF0B8;
    localparam logic [15:0] CRC_POLY    = 16'h8408;

    localparam int HEADER_LEN        = 12;
    localparam int ACARS_TAIL_FIRST  = 21;
    localparam int ACARS_TAIL_LEN    = 4;

    localparam logic [COUNT_W-1:0] MIN_FRAME_LEN   = 12'd11;
    localparam logic [COUNT_W-1:0] ACARS_MIN_LEN   = 12'd15;
    localparam logic [COUNT_W-1:0] ACARS_BLOCK_LEN = 12'd30;
    localparam logic [COUNT_W-1:0] ACARS_DOWN_LEN  = 12'd41;

    localparam logic [7:0] ACARS_PREFIX_FF = 8'hFF;
    localparam logic [7:0] ACARS_PREFIX_01 = 8'h01;
    localparam logic [7:0] ASCII_DEL_BYTE  = 8'h7F;
    localparam logic [6:0] CHAR_DEL        = 7'h7F;
    localparam logic [6:0] CHAR_ETX        = 7'h03;
    localparam logic [6:0] CHAR_ETB        = 7'h17;
    localparam logic [6:0] CHAR_STX        = 7'h02;
    localparam logic [6:0] CHAR_SPACE      = 7'h20;
    localparam logic [6:0] CHAR_LOWER_D    = 7'h64;
    localparam logic [6:0] CHAR_DIGIT_0    = 7'h30;
    localparam logic [6:0] CHAR_DIGIT_9    = 7'h39;
    localparam logic [5:0] U_CODE_MASK     = 6'h3B;

    localparam logic [1:0] FS_SHORT   = 2'd0;
    localparam logic [1:0] FS_BAD_FCS = 2'd1;
    localparam logic [1:0] FS_VALID   = 2'd2;

    localparam logic [1:0] CLASS_I = 2'd0;
    localparam logic [1:0] CLASS_S = 2'd1;
    localparam logic [1:0] CLASS_U = 2'd2;

    localparam logic [1:0] ACARS_NONE = 2'd0;
    localparam logic [1:0] ACARS_OK   = 2'd1;
    localparam logic [1:0] ACARS_BAD  = 2'd2;

    typedef struct packed {
        logic [COUNT_W-1:0]                len;
        logic                              fcs_good;
        logic                              bcs_zero;
        logic [7:0]                        tail_2;
        logic [7:0]                        tail_5;
        logic [HEADER_LEN-1:0][7:0]        header;
        logic [ACARS_TAIL_LEN-1:0][7:0]    acars;
    } frame_view_t;

    typedef struct packed {
        logic [1:0]  frame_status;
        logic [23:0] dest_address;
        logic [2:0]  dest_kind;
        logic        dst_status;
        logic [23:0] source_address;
        logic [2:0]  source_kind;
        logic        src_status;
        logic [1:0]  frame_class;
        logic [5:0]  command_code;
        logic [1:0]  acars_status;
        logic        acars_bcs_ok;
        logic [13:0] msg_label;
    } summary_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ rtl/core/avlc_fhp_accum.sv @@
// ----------------------------------------------------------------------------
// AVLC frame accumulator
// Runs the FCS and block check CRCs and keeps the header and tail octets
// of the frame in progress; all but the tail and BCS view include the new byte.
// ----------------------------------------------------------------------------
module avlc_fhp_accum #(
    parameter int MAX_FRAME_LEN = avlc_fhp_pkg::MAX_FRAME_LEN_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      byte_accept,
    input  logic [7:0]                byte_value,
    input  logic                      last_byte,
    output avlc_fhp_pkg::frame_view_t view
);
    import avlc_fhp_pkg::*;

    localparam int CountCapInt = (MAX_FRAME_LEN > COUNT_MAX) ? COUNT_MAX : MAX_FRAME_LEN;
    localparam logic [COUNT_W-1:0] CountCap = COUNT_W'(CountCapInt);

    logic [15:0]        fcs_crc_reg;
    logic [15:0]        fcs_crc_next;
    logic [15:0]        bcs_hist_reg [3];
    logic [15:0]        bcs_new;
    logic [7:0]         tail_reg [5];
    logic [7:0]         header_reg [HEADER_LEN];
    logic [7:0]         header_next [HEADER_LEN];
    logic [7:0]         label_oct_reg [ACARS_TAIL_LEN];
    logic [7:0]         label_oct_next [ACARS_TAIL_LEN];
    logic [COUNT_W-1:0] byte_count_reg;
    logic [COUNT_W-1:0] byte_count_next;
    logic               store_en;

    always_comb
    begin
        store_en     = (byte_count_reg < CountCap);
        fcs_crc_next = crc16_byte(fcs_crc_reg, byte_value);
        bcs_new      = (byte_count_reg >= COUNT_W'(HEADER_LEN))
                       ? crc16_byte(bcs_hist_reg[0], byte_value) : 16'h0000;
        for (int k = 0; k < HEADER_LEN; k++) begin
            header_next[k] = (store_en && byte_count_reg == COUNT_W'(k))
                             ? byte_value : header_reg[k];
        end
        for (int k = 0; k < ACARS_TAIL_LEN; k++) begin
            label_oct_next[k] = (store_en && byte_count_reg == COUNT_W'(ACARS_TAIL_FIRST + k))
                                ? byte_value : label_oct_reg[k];
        end
        byte_count_next = store_en ? byte_count_reg + 1'b1 : byte_count_reg;

        view.len      = byte_count_next;
        view.fcs_good = (fcs_crc_next == FCS_RESIDUE);
        view.bcs_zero = (bcs_hist_reg[2] == 16'h0000);
        view.tail_2   = tail_reg[1];
        view.tail_5   = tail_reg[4];
        for (int k = 0; k < HEADER_LEN; k++) begin
            view.header[k] = header_next[k];
        end
        for (int k = 0; k < ACARS_TAIL_LEN; k++) begin
            view.acars[k] = label_oct_next[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fcs_crc_reg    <= FCS_INIT;
            byte_count_reg <= '0;
            for (int k = 0; k < 3; k++) bcs_hist_reg[k] <= '0;
            for (int k = 0; k < 5; k++) tail_reg[k] <= '0;
            for (int k = 0; k < HEADER_LEN; k++) header_reg[k] <= '0;
            for (int k = 0; k < ACARS_TAIL_LEN; k++) label_oct_reg[k] <= '0;
        end else if (byte_accept) begin
            if (last_byte) begin
                fcs_crc_reg    <= FCS_INIT;
                byte_count_reg <= '0;
                for (int k = 0; k < 3; k++) bcs_hist_reg[k] <= '0;
                for (int k = 0; k < 5; k++) tail_reg[k] <= '0;
                for (int k = 0; k < HEADER_LEN; k++) header_reg[k] <= '0;
                for (int k = 0; k < ACARS_TAIL_LEN; k++) label_oct_reg[k] <= '0;
            end else begin
                fcs_crc_reg     <= fcs_crc_next;
                byte_count_reg  <= byte_count_next;
                bcs_hist_reg[0] <= bcs_new;
                bcs_hist_reg[1] <= bcs_hist_reg[0];
                bcs_hist_reg[2] <= bcs_hist_reg[1];
                tail_reg[0]     <= byte_value;
                for (int k = 1; k < 5; k++) tail_reg[k] <= tail_reg[k-1];
                for (int k = 0; k < HEADER_LEN; k++) header_reg[k] <= header_next[k];
                for (int k = 0; k < ACARS_TAIL_LEN; k++) label_oct_reg[k] <= label_oct_next[k];
            end
        end
    end

    a_count_capped: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= CountCap)
        else $error("Byte count exceeds its saturation limit.");

    a_frame_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_accept && last_byte) |=> (byte_count_reg == '0 && fcs_crc_reg == FCS_INIT))
        else $error("Frame state was not cleared after the final byte.");

endmodule

@@ rtl/core/avlc_fhp_decode.sv @@
// ----------------------------------------------------------------------------
// AVLC frame summary decoder
// Derives frame status, DLC addresses, link control fields and the ACARS
// checks from the accumulator view at the final byte.
// ----------------------------------------------------------------------------
module avlc_fhp_decode (
    input  avlc_fhp_pkg::frame_view_t view,
    output avlc_fhp_pkg::summary_t    summary
);
    import avlc_fhp_pkg::*;

    function automatic logic [27:0] dlc_addr(input logic [7:0] o0, input logic [7:0] o1,
                                             input logic [7:0] o2, input logic [7:0] o3);
        logic [27:0] v;
        logic [27:0] r;
        v = 28'(o0[7:1]) | (28'(o1) << 6) | (28'(o2) << 13) | (28'(o3 & 8'hFE) << 20);
        for (int i = 0; i < 28; i++) begin
            r[27-i] = v[i];
        end
        return r;
    endfunction

    function automatic logic [6:0] printable(input logic [7:0] c);
        logic [6:0] s;
        s = c[6:0];
        return (s >= CHAR_SPACE && s != CHAR_DEL) ? s : CHAR_SPACE;
    endfunction

    logic [27:0] dst_raw;
    logic [27:0] src_raw;
    logic [7:0]  lcf;
    logic [6:0]  term;
    logic [6:0]  label_1;
    logic [6:0]  block_id;
    logic [6:0]  label_1_char;
    logic        downlink;
    logic        acars_prefix;
    logic [1:0]  acars_st;

    always_comb
    begin
        dst_raw      = dlc_addr(view.header[0], view.header[1], view.header[2], view.header[3]);
        src_raw      = dlc_addr(view.header[4], view.header[5], view.header[6], view.header[7]);
        lcf          = view.header[8];
        term         = view.tail_5[6:0];
        label_1      = view.acars[1][6:0];
        block_id     = view.acars[2][6:0];
        downlink     = (block_id >= CHAR_DIGIT_0) && (block_id <= CHAR_DIGIT_9);
        label_1_char = (label_1 == CHAR_DEL) ? CHAR_LOWER_D : printable(view.acars[1]);
        acars_prefix = (view.len >= ACARS_MIN_LEN) && (view.header[9] == ACARS_PREFIX_FF)
                       && (view.header[10] == ACARS_PREFIX_FF)
                       && (view.header[11] == ACARS_PREFIX_01);
        acars_st     = ACARS_BAD;
        summary      = '0;

        priority if (view.len < MIN_FRAME_LEN) begin
            summary.frame_status = FS_SHORT;
        end else if (!view.fcs_good) begin
            summary.frame_status = FS_BAD_FCS;
        end else begin
            summary.frame_status   = FS_VALID;
            summary.dest_address   = dst_raw[23:0];
            summary.dest_kind      = dst_raw[26:24];
            summary.dst_status     = dst_raw[27];
            summary.source_address = src_raw[23:0];
            summary.source_kind    = src_raw[26:24];
            summary.src_status     = src_raw[27];
            priority if (!lcf[0]) begin
                summary.frame_class = CLASS_I;
                if (acars_prefix) begin
                    if (view.len >= ACARS_BLOCK_LEN && view.tail_2 == ASCII_DEL_BYTE) begin
                        summary.acars_bcs_ok = view.bcs_zero;
                        if (term == CHAR_ETX || term == CHAR_ETB) begin
                            summary.msg_label = {printable(view.acars[0]), label_1_char};
                            priority if (view.len <= ACARS_BLOCK_LEN) begin
                                acars_st = downlink ? ACARS_BAD : ACARS_OK;
                            end else if (view.acars[3][6:0] != CHAR_STX) begin
                                acars_st = ACARS_BAD;
                            end else if (downlink && view.len < ACARS_DOWN_LEN) begin
                                acars_st = ACARS_BAD;
                            end else begin
                                acars_st = ACARS_OK;
                            end
                        end
                    end
                    summary.acars_status = acars_st;
                end
            end else if (lcf[1:0] == 2'b01) begin
                summary.frame_class  = CLASS_S;
                summary.command_code = {4'd0, lcf[3:2]};
            end else begin
                summary.frame_class  = CLASS_U;
                summary.command_code = lcf[5:0] & U_CODE_MASK;
            end
        end
    end

endmodule

@@ rtl/core/avlc_fhp_out.sv @@
// ----------------------------------------------------------------------------
// AVLC summary output stage
// Output register with one skid entry so that bytes keep flowing while a
// finished summary waits to be taken.
// ----------------------------------------------------------------------------
module avlc_fhp_out (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  avlc_fhp_pkg::summary_t push_data,
    output logic                   space,
    output logic                   out_valid,
    input  logic                   out_ready,
    output avlc_fhp_pkg::summary_t out_data
);
    import avlc_fhp_pkg::*;

    summary_t out_data_reg;
    summary_t skid_data_reg;
    logic     out_valid_reg;
    logic     skid_valid_reg;
    logic     pop;

    assign pop       = out_valid_reg && out_ready;
    assign space     = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_data_reg <= push_data;
            end else begin
                skid_data_reg <= push_data;
            end
        end
    end

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("Skid entry is held while the output register is empty.");

    a_skid_moves_up: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && pop) |=> (out_valid_reg && out_data_reg == $past(skid_data_reg)))
        else $error("Skid entry was not moved to the output register.");

endmodule

@@ rtl/core/avlc_frame_header_parser_unit.sv @@
// ----------------------------------------------------------------------------
// AVLC frame header parser unit
// The summary is registered; out_valid rises in the cycle after the final byte while the output register is free.
// Throughput: one byte per cycle while in_ready is high, set by the combinational CRC and decode path.
// in_ready drops only while both the output register and its skid entry hold.
// Reset clears the CRCs, byte count, stored octets and all pending summaries.
// ----------------------------------------------------------------------------
module avlc_frame_header_parser_unit #(
    parameter int MAX_FRAME_LEN = avlc_fhp_pkg::MAX_FRAME_LEN_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  byte_value,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  frame_status,
    output logic [23:0] dest_address,
    output logic [2:0]  dest_kind,
    output logic        dst_status,
    output logic [23:0] source_address,
    output logic [2:0]  source_kind,
    output logic        src_status,
    output logic [1:0]  frame_class,
    output logic [5:0]  command_code,
    output logic [1:0]  acars_status,
    output logic        acars_bcs_ok,
    output logic [13:0] msg_label
);
    import avlc_fhp_pkg::*;

    frame_view_t view;
    summary_t    summary;
    summary_t    result;
    logic        byte_accept;
    logic        space;

    assign in_ready    = space;
    assign byte_accept = in_valid && space;

    avlc_fhp_accum #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN)
    ) u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_accept (byte_accept),
        .byte_value  (byte_value),
        .last_byte   (last_byte),
        .view        (view)
    );

    avlc_fhp_decode u_decode (
        .view    (view),
        .summary (summary)
    );

    avlc_fhp_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (byte_accept && last_byte),
        .push_data (summary),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (result)
    );

    assign frame_status   = result.frame_status;
    assign dest_address   = result.dest_address;
    assign dest_kind      = result.dest_kind;
    assign dst_status     = result.dst_status;
    assign source_address = result.source_address;
    assign source_kind    = result.source_kind;
    assign src_status     = result.src_status;
    assign frame_class    = result.frame_class;
    assign command_code   = result.command_code;
    assign acars_status   = result.acars_status;
    assign acars_bcs_ok   = result.acars_bcs_ok;
    assign msg_label      = result.msg_label;

endmodule
